// ===== rtl/crls_pkg.sv =====
// Shared types, constants and CRC helpers for the record log scanner.
`timescale 1ns / 1ps

package crls_pkg;

  localparam int MAX_RECORDS_DEF = 1024;

  localparam int IDX_W     = 10;  // width of the reported free slot index
  localparam int CFG_IDX_W = 1;

  localparam logic [31:0] COMMIT_MAGIC   = 32'h4643_4944;
  localparam logic [31:0] ERASED_WORD    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [23:0] RECORD_VERSION = 24'd1;

  localparam logic [7:0] MAX_DEVICE_RST     = 8'd63;
  localparam logic [7:0] DEFAULT_DEVICE_RST = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DEVICE     = 1'b0,
    REG_DEFAULT_DEVICE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] commit_word;
    logic [31:0] sequence_word;
    logic [31:0] data_word;
    logic [31:0] crc_word;
    logic        last_record;
  } rec_t;

  typedef struct packed {
    logic             valid_seen;
    logic [7:0]       newest_device;
    logic [31:0]      latest_sequence;
    logic             free_slot_found;
    logic [IDX_W-1:0] free_slot_index;
    logic [31:0]      next_sequence;
    logic             overflow;
  } res_t;

  typedef logic [63:0][31:0] crc_cols_t;

  // Bit-serial reflected CRC-32 over {data, seq}, LSB first. Only used at
  // elaboration to build the XOR matrix below.
  function automatic logic [31:0] crc_of(input logic [63:0] msg);
    logic [31:0] crc;
    logic        fb;
    crc = CRC_INIT;
    for (int i = 0; i < 64; i++) begin
      fb  = crc[0] ^ msg[i];
      crc = (crc >> 1) ^ (fb ? CRC_POLY : 32'h0);
    end
    return ~crc;
  endfunction

  // CRC is affine in the message: crc(x) = crc(0) ^ XOR of columns of set bits.
  function automatic crc_cols_t crc_columns();
    crc_cols_t   cols;
    logic [31:0] base;
    base = crc_of(64'h0);
    for (int i = 0; i < 64; i++) begin
      cols[i] = crc_of(64'h1 << i) ^ base;
    end
    return cols;
  endfunction

endpackage

// ===== rtl/config_record_log_scanner_core.sv =====
// Top level of the record log scanner: record register, checks, scan state and result register.
`timescale 1ns / 1ps

// Takes one 16-byte log record per cycle in slot order while rec_stall is
// low; each request is registered, checked (commit marker, version, device
// limit, CRC-32) and folded into the scan state as it leaves the record
// register, from which the result of a last record is registered. The record
// that has last_record set loads the result register, which is held until
// taken; the input stalls only when a last record finds that register still
// full. Records past MAX_RECORDS in one scan are skipped and flagged as
// overflow. Configuration writes are always ready.
module config_record_log_scanner_core
  import crls_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  output logic                 rec_stall,
  input  rec_t                 rec,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  // configuration
  logic [7:0] max_device;
  logic [7:0] default_device;

  // record register
  logic s1_valid;
  rec_t s1;
  logic s1_adv;

  // scan state
  logic             have_valid;
  logic [31:0]      best_sequence;
  logic [7:0]       best_device;
  logic             have_free;
  logic [IDX_W-1:0] free_index;
  logic [CNT_W-1:0] slot_count;
  logic             overflowed;

  logic             have_valid_next;
  logic [31:0]      best_sequence_next;
  logic [7:0]       best_device_next;
  logic             have_free_next;
  logic [IDX_W-1:0] free_index_next;
  logic             overflowed_next;

  logic [31:0]            calc_crc;
  logic                   in_range;
  logic                   erased;
  logic                   rec_ok;
  logic [31:0]            diff;
  logic                   newer;
  logic [CNT_W+IDX_W-1:0] count_wide;
  logic [31:0]            seq_inc;
  res_t                   res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_device     <= MAX_DEVICE_RST;
      default_device <= DEFAULT_DEVICE_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_DEVICE:     max_device     <= cfg_data;
        REG_DEFAULT_DEVICE: default_device <= cfg_data;
        default: ;
      endcase
    end
  end

  // A last record may only move on when the result register frees up.
  assign s1_adv    = s1_valid && (!s1.last_record || !res_valid || !res_stall);
  assign rec_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rec_stall) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && !rec_stall) begin
      s1 <= rec;
    end
  end

  crls_crc32 u_crc (
    .seq  (s1.sequence_word),
    .data (s1.data_word),
    .crc  (calc_crc)
  );

  assign in_range = slot_count < CNT_W'(MAX_RECORDS);
  assign erased   = (s1.commit_word == ERASED_WORD) && (s1.sequence_word == ERASED_WORD) &&
                    (s1.data_word == ERASED_WORD) && (s1.crc_word == ERASED_WORD);
  assign rec_ok   = (s1.commit_word == COMMIT_MAGIC) &&
                    (s1.data_word[31:8] == RECORD_VERSION) &&
                    (s1.data_word[7:0] <= max_device) &&
                    (s1.crc_word == calc_crc);
  // serial-number compare: newer when the signed difference is positive
  assign diff       = s1.sequence_word - best_sequence;
  assign newer      = (diff != 32'h0) && !diff[31];
  assign count_wide = {{IDX_W{1'b0}}, slot_count};

  always_comb begin
    have_valid_next    = have_valid;
    best_sequence_next = best_sequence;
    best_device_next   = best_device;
    have_free_next     = have_free;
    free_index_next    = free_index;
    overflowed_next    = overflowed;
    if (in_range) begin
      if (!have_free && erased) begin
        have_free_next  = 1'b1;
        free_index_next = count_wide[IDX_W-1:0];
      end
      if (rec_ok && (!have_valid || newer)) begin
        have_valid_next    = 1'b1;
        best_sequence_next = s1.sequence_word;
        best_device_next   = s1.data_word[7:0];
      end
    end else begin
      overflowed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_valid    <= 1'b0;
      best_sequence <= '0;
      best_device   <= '0;
      have_free     <= 1'b0;
      free_index    <= '0;
      slot_count    <= '0;
      overflowed    <= 1'b0;
    end else if (s1_adv) begin
      if (s1.last_record) begin
        have_valid    <= 1'b0;
        best_sequence <= '0;
        best_device   <= '0;
        have_free     <= 1'b0;
        free_index    <= '0;
        slot_count    <= '0;
        overflowed    <= 1'b0;
      end else begin
        have_valid    <= have_valid_next;
        best_sequence <= best_sequence_next;
        best_device   <= best_device_next;
        have_free     <= have_free_next;
        free_index    <= free_index_next;
        overflowed    <= overflowed_next;
        if (in_range) begin
          slot_count <= slot_count + CNT_W'(1);
        end
      end
    end
  end

  assign seq_inc = best_sequence_next + 32'd1;

  always_comb begin
    res_next.valid_seen      = have_valid_next;
    res_next.newest_device   = have_valid_next ? best_device_next : default_device;
    res_next.latest_sequence = have_valid_next ? best_sequence_next : 32'h0;
    res_next.free_slot_found = have_free_next;
    res_next.free_slot_index = have_free_next ? free_index_next : '0;
    // zero is never handed out as a sequence
    res_next.next_sequence   = (!have_valid_next || seq_inc == 32'h0) ? 32'd1 : seq_inc;
    res_next.overflow        = overflowed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1.last_record) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.last_record) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/crls_crc32.sv =====
// Combinational CRC-32 over the sequence and data words of one record.
`timescale 1ns / 1ps

module crls_crc32
  import crls_pkg::*;
(
  input  logic [31:0] seq,
  input  logic [31:0] data,
  output logic [31:0] crc
);

  localparam logic [31:0] CRC_BASE = crc_of(64'h0);
  localparam crc_cols_t   CRC_COLS = crc_columns();

  logic [63:0] msg;

  assign msg = {data, seq};

  always_comb begin
    crc = CRC_BASE;
    for (int i = 0; i < 64; i++) begin
      crc = crc ^ (msg[i] ? CRC_COLS[i] : 32'h0);
    end
  end

endmodule
